// ===== design/assert_macros.svh =====
// Assertion macros for the gradient scatter unit.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BGS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define BGS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define BGS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BGS_ASSERT_ALWAYS(lbl, cond, msg)
`endif
`endif

// ===== design/bgs_pkg.sv =====
// Package for the gradient scatter unit: sizes, codes, payload and
// controller/datapath interface types. No dependencies.
package bgs_pkg;

    localparam int MAX_COEFF   = 16384;
    localparam int TILE_VOXELS = 512;
    localparam int ROW_WEIGHTS = 64;
    localparam int COMPONENTS  = 3;
    localparam int SPAN        = 4;
    localparam int COEFF_W     = $clog2(MAX_COEFF);
    localparam int WT_AW       = $clog2(TILE_VOXELS * ROW_WEIGHTS);
    localparam int NB_W        = $clog2(SPAN * SPAN * SPAN);
    localparam int PTR_W       = 24;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_SC_CUR = 3'd1;
    localparam logic [2:0] OP_SC_TOT = 3'd2;
    localparam logic [2:0] OP_FOLD   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;
    localparam logic [2:0] OP_RSVD6  = 3'd6;
    localparam logic [2:0] OP_RSVD7  = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic CFG_GRID_X = 1'b0;
    localparam logic CFG_GRID_Y = 1'b1;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [5:0]         pos_x;
        logic [5:0]         pos_y;
        logic [5:0]         pos_z;
        logic [8:0]         tile_offset;
        logic [5:0]         weight_index;
        logic signed [31:0] value;
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic signed [15:0] grad_z;
        logic [15:0]        lambda;
        logic [13:0]        coeff_index;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [47:0] score_sum;
        logic signed [31:0] read_value;
    } out_t;

    typedef struct packed {
        logic               capture;
        logic               load_wt;
        logic               chk1;
        logic               chk2;
        logic               chk3;
        logic               scatter;
        logic               sc_wr;
        logic               nb_next;
        logic               fold_score;
        logic               fold;
        logic               fold_wr;
        logic               clr_wr;
        logic               finish;
        logic [1:0]         comp;
        logic [NB_W-1:0]    nb;
        logic [COEFF_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       oor;
        logic       out_valid;
    } sts_t;

endpackage

// ===== design/bgs_datapath.sv =====
// Datapath: item register, address arithmetic, gradient and weight memories,
// saturating accumulators and result register. Depends on bgs_pkg.
module bgs_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  bgs_pkg::cmd_t cmd,
    output bgs_pkg::sts_t sts,
    input  bgs_pkg::in_t  in_data,
    input  logic [6:0]    grid_x,
    input  logic [6:0]    grid_y,
    input  logic          out_ready,
    output logic          out_valid,
    output bgs_pkg::out_t out_data
);
    import bgs_pkg::*;

    logic signed [31:0] cur_mem [MAX_COEFF];
    logic signed [31:0] tot_mem [MAX_COEFF];
    logic [15:0]        wt_mem  [TILE_VOXELS * ROW_WEIGHTS];

    in_t                item_reg;
    logic               oor_reg;
    logic               sat_reg;
    logic signed [47:0] score_reg;
    logic               out_valid_reg;
    out_t               out_reg;
    logic [PTR_W-1:0]   a_reg, b_reg, plane_reg, plane3_reg, row3_reg;
    logic [PTR_W-1:0]   addr_reg, rowp_reg, planep_reg;
    logic signed [31:0] cur_rd_reg, tot_rd_reg;
    logic [15:0]        wt_rd_reg;

    logic [COEFF_W-1:0] sc_addr, cur_addr, tot_addr;
    logic [WT_AW-1:0]   wt_addr;
    logic               cur_we, tot_we;
    logic signed [31:0] cur_wd, tot_wd;
    logic signed [15:0] g_sel;
    logic signed [32:0] sc_prod;
    logic signed [33:0] sc_sum;
    logic signed [31:0] sc_val;
    logic               sc_ovf;
    logic signed [48:0] f_prod, f_rnd;
    logic signed [37:0] f_sum;
    logic signed [31:0] f_val;
    logic               f_ovf;
    logic signed [48:0] s_prod, s_rnd, s_sum;
    logic signed [47:0] s_val;
    logic               s_ovf;
    logic [PTR_W-1:0]   top;
    logic               chk_oor, cap_oor;

    // address of the current scatter access
    assign sc_addr = COEFF_W'(addr_reg + PTR_W'(cmd.comp));
    assign cur_addr = cmd.scatter ? sc_addr : cmd.idx;
    assign tot_addr = cmd.scatter ? sc_addr
                    : ((cmd.fold || cmd.clr_wr) ? cmd.idx : COEFF_W'(item_reg.coeff_index));
    assign wt_addr = cmd.load_wt ? WT_AW'({item_reg.tile_offset, item_reg.weight_index})
                                 : WT_AW'({item_reg.tile_offset, cmd.nb});

    always_comb
    begin
        unique case (cmd.comp)
            2'd0:    g_sel = item_reg.grad_x;
            2'd1:    g_sel = item_reg.grad_y;
            default: g_sel = item_reg.grad_z;
        endcase
    end

    // scatter: entry + derivative * weight
    assign sc_prod = g_sel * $signed({1'b0, wt_rd_reg});
    assign sc_sum  = 34'((item_reg.cmd == OP_SC_CUR) ? cur_rd_reg : tot_rd_reg) + 34'(sc_prod);
    assign sc_ovf  = (sc_sum[33:31] != 3'b000) && (sc_sum[33:31] != 3'b111);
    assign sc_val  = sc_ovf ? (sc_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sc_sum[31:0];

    // fold: total + round(lambda * current / 4096)
    assign f_prod = $signed({1'b0, item_reg.lambda}) * cur_rd_reg;
    assign f_rnd  = (f_prod + 49'sd2048) >>> 12;
    assign f_sum  = 38'(tot_rd_reg) + 38'(f_rnd);
    assign f_ovf  = (f_sum[37:31] != 7'h00) && (f_sum[37:31] != 7'h7F);
    assign f_val  = f_ovf ? (f_sum[37] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : f_sum[31:0];

    assign s_prod = $signed({1'b0, item_reg.lambda}) * item_reg.value;
    assign s_rnd  = (s_prod + 49'sd2048) >>> 12;
    assign s_sum  = 49'(score_reg) + s_rnd;
    assign s_ovf  = s_sum[48] != s_sum[47];
    assign s_val  = s_ovf ? (s_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : s_sum[47:0];

    assign top = PTR_W'(3) * (a_reg + PTR_W'(item_reg.pos_x) + PTR_W'(3)) + PTR_W'(2);
    assign chk_oor = (32'(item_reg.tile_offset) >= 32'(TILE_VOXELS))
                  || ({1'b0, item_reg.pos_x} + 7'd3 >= grid_x)
                  || ({1'b0, item_reg.pos_y} + 7'd3 >= grid_y)
                  || (32'(top) >= 32'(MAX_COEFF));
    assign cap_oor = (in_data.cmd == OP_LOAD)
                   ? (32'(in_data.tile_offset) >= 32'(TILE_VOXELS))
                   : ((in_data.cmd == OP_READ) && (32'(in_data.coeff_index) >= 32'(MAX_COEFF)));

    assign cur_we = (cmd.sc_wr && item_reg.cmd == OP_SC_CUR) || cmd.fold_wr || cmd.clr_wr;
    assign cur_wd = cmd.sc_wr ? sc_val : 32'sd0;
    assign tot_we = (cmd.sc_wr && item_reg.cmd == OP_SC_TOT) || cmd.fold_wr || cmd.clr_wr;
    assign tot_wd = cmd.sc_wr ? sc_val : (cmd.fold_wr ? f_val : 32'sd0);

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_addr] <= cur_wd;
        end
        cur_rd_reg <= cur_mem[cur_addr];
        if (tot_we)
        begin
            tot_mem[tot_addr] <= tot_wd;
        end
        tot_rd_reg <= tot_mem[tot_addr];
        if (cmd.load_wt && !oor_reg)
        begin
            wt_mem[wt_addr] <= item_reg.value[15:0];
        end
        wt_rd_reg <= wt_mem[wt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.chk1)
        begin
            a_reg     <= (PTR_W'(item_reg.pos_z) + PTR_W'(3)) * PTR_W'(grid_y);
            b_reg     <= PTR_W'(item_reg.pos_z) * PTR_W'(grid_y);
            plane_reg <= PTR_W'(grid_x) * PTR_W'(grid_y);
        end
        if (cmd.chk2)
        begin
            a_reg      <= (a_reg + PTR_W'(item_reg.pos_y) + PTR_W'(3)) * PTR_W'(grid_x);
            b_reg      <= (b_reg + PTR_W'(item_reg.pos_y)) * PTR_W'(grid_x);
            plane3_reg <= PTR_W'(3) * plane_reg;
            row3_reg   <= PTR_W'(3) * PTR_W'(grid_x);
        end
        if (cmd.chk3)
        begin
            addr_reg   <= PTR_W'(3) * (b_reg + PTR_W'(item_reg.pos_x));
            rowp_reg   <= PTR_W'(3) * (b_reg + PTR_W'(item_reg.pos_x));
            planep_reg <= PTR_W'(3) * (b_reg + PTR_W'(item_reg.pos_x));
        end
        else if (cmd.nb_next)
        begin
            priority if (cmd.nb[1:0] != 2'd3)
            begin
                addr_reg <= addr_reg + PTR_W'(3);
            end
            else if (cmd.nb[3:2] != 2'd3)
            begin
                rowp_reg <= rowp_reg + row3_reg;
                addr_reg <= rowp_reg + row3_reg;
            end
            else
            begin
                planep_reg <= planep_reg + plane3_reg;
                rowp_reg   <= planep_reg + plane3_reg;
                addr_reg   <= planep_reg + plane3_reg;
            end
        end
        if (cmd.finish)
        begin
            out_reg.status     <= oor_reg ? ST_RANGE : (sat_reg ? ST_SAT : ST_OK);
            out_reg.score_sum  <= score_reg;
            out_reg.read_value <= (item_reg.cmd == OP_READ && !oor_reg) ? tot_rd_reg : 32'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oor_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            score_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                oor_reg <= cap_oor;
                sat_reg <= 1'b0;
            end
            else
            begin
                if (cmd.chk3)
                begin
                    oor_reg <= chk_oor;
                end
                if ((cmd.sc_wr && sc_ovf) || (cmd.fold_wr && f_ovf)
                    || (cmd.fold_score && s_ovf))
                begin
                    sat_reg <= 1'b1;
                end
            end
            if (cmd.fold_score)
            begin
                score_reg <= s_val;
            end
            else if (cmd.clr_wr)
            begin
                score_reg <= '0;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.op        = item_reg.cmd;
    assign sts.oor       = oor_reg;
    assign sts.out_valid = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;

endmodule

// ===== design/bgs_ctrl.sv =====
// Controller: sequences clearing sweeps, range check, neighbor scatter,
// fold sweep and result hand-off. Depends on bgs_pkg.
module bgs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          out_ready,
    input  bgs_pkg::sts_t sts,
    output bgs_pkg::cmd_t cmd
);
    import bgs_pkg::*;

    localparam logic [3:0] S_RST  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_CHK1 = 4'd3;
    localparam logic [3:0] S_CHK2 = 4'd4;
    localparam logic [3:0] S_CHK3 = 4'd5;
    localparam logic [3:0] S_CHKD = 4'd6;
    localparam logic [3:0] S_SRD  = 4'd7;
    localparam logic [3:0] S_SWR  = 4'd8;
    localparam logic [3:0] S_FSC  = 4'd9;
    localparam logic [3:0] S_FRD  = 4'd10;
    localparam logic [3:0] S_FWR  = 4'd11;
    localparam logic [3:0] S_CLR  = 4'd12;
    localparam logic [3:0] S_RD   = 4'd13;
    localparam logic [3:0] S_FIN  = 4'd14;

    localparam logic [COEFF_W-1:0] IDX_LAST = COEFF_W'(MAX_COEFF - 1);
    localparam logic [NB_W-1:0]    NB_LAST  = NB_W'(SPAN * SPAN * SPAN - 1);

    logic [3:0]         state_reg, state_next;
    logic [COEFF_W-1:0] idx_reg, idx_next;
    logic [NB_W-1:0]    nb_reg, nb_next;
    logic [1:0]         comp_reg, comp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST;
            idx_reg   <= '0;
            nb_reg    <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            nb_reg    <= nb_next;
            comp_reg  <= comp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        nb_next    = nb_reg;
        comp_next  = comp_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        cmd.nb     = nb_reg;
        cmd.idx    = idx_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_RST:
            begin
                cmd.clr_wr = 1'b1;
                idx_next   = idx_reg + 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                idx_next = '0;
                unique case (sts.op)
                    OP_LOAD:
                    begin
                        cmd.load_wt = 1'b1;
                        state_next  = S_FIN;
                    end
                    OP_SC_CUR, OP_SC_TOT: state_next = S_CHK1;
                    OP_FOLD:              state_next = S_FSC;
                    OP_CLEAR:             state_next = S_CLR;
                    OP_READ:              state_next = S_RD;
                    default:              state_next = S_FIN;
                endcase
            end
            S_CHK1:
            begin
                cmd.chk1   = 1'b1;
                state_next = S_CHK2;
            end
            S_CHK2:
            begin
                cmd.chk2   = 1'b1;
                state_next = S_CHK3;
            end
            S_CHK3:
            begin
                cmd.chk3   = 1'b1;
                nb_next    = '0;
                comp_next  = '0;
                state_next = S_CHKD;
            end
            S_CHKD:
            begin
                state_next = sts.oor ? S_FIN : S_SRD;
            end
            S_SRD:
            begin
                cmd.scatter = 1'b1;
                state_next  = S_SWR;
            end
            S_SWR:
            begin
                cmd.scatter = 1'b1;
                cmd.sc_wr   = 1'b1;
                state_next  = S_SRD;
                if (comp_reg == 2'd2)
                begin
                    comp_next = '0;
                    if (nb_reg == NB_LAST)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.nb_next = 1'b1;
                        nb_next     = nb_reg + 1'b1;
                    end
                end
                else
                begin
                    comp_next = comp_reg + 1'b1;
                end
            end
            S_FSC:
            begin
                cmd.fold_score = 1'b1;
                state_next     = S_FRD;
            end
            S_FRD:
            begin
                cmd.fold   = 1'b1;
                state_next = S_FWR;
            end
            S_FWR:
            begin
                cmd.fold    = 1'b1;
                cmd.fold_wr = 1'b1;
                idx_next    = idx_reg + 1'b1;
                state_next  = (idx_reg == IDX_LAST) ? S_FIN : S_FRD;
            end
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                idx_next   = idx_reg + 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_RD:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!sts.out_valid || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/bspline_gradient_scatter_unit.sv =====
// Per request, load and unused codes go straight to the result; read passes a read
// state; scatter runs a range check, then a read and a write for each of 64 neighbors
// x 3 components, and a skipped scatter stops after the check; fold updates the
// score, then reads and writes each entry; clear writes each entry. One request at
// a time; the next is taken while a result waits. Depends on bgs_pkg, bgs_ctrl,
// bgs_datapath. Reset: a clearing pass first zeroes both gradient memories.
`include "assert_macros.svh"
module bspline_gradient_scatter_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bgs_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output bgs_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [6:0]    cfg_data
);
    import bgs_pkg::*;

    cmd_t       cmd;
    sts_t       sts;
    logic [6:0] grid_x_reg, grid_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_x_reg <= 7'd16;
            grid_y_reg <= 7'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_X: grid_x_reg <= cfg_data;
                CFG_GRID_Y: grid_y_reg <= cfg_data;
            endcase
        end
    end

    bgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bgs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .grid_x    (grid_x_reg),
        .grid_y    (grid_y_reg),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    `BGS_ASSERT_IMPLY(a_finish_free, cmd.finish, (!out_valid || out_ready), "result overwritten")
    `BGS_ASSERT_IMPLY(a_skip_no_write, cmd.sc_wr, !sts.oor, "write on skipped scatter")
    `BGS_ASSERT_ALWAYS(a_one_writer, $onehot0({cmd.sc_wr, cmd.fold_wr, cmd.clr_wr, cmd.load_wt}), "writers overlap")

endmodule

// ===== bench/tb_bspline_gradient_scatter_unit.sv =====
// Testbench for bspline_gradient_scatter_unit: drives random and directed requests,
// predicts each result with a scoreboard class and checks it field by field.
// Depends on bgs_pkg and the unit's RTL.
`timescale 1ns / 100ps
import bgs_pkg::*;

class grad_scoreboard;
    int        cur_grad [MAX_COEFF];
    int        tot_grad [MAX_COEFF];
    bit [15:0] weights [TILE_VOXELS * ROW_WEIGHTS];
    longint    score;
    int        grid_x;
    int        grid_y;
    out_t      pending_q [$];
    int        fails;

    function new();
        foreach (cur_grad[i])
        begin
            cur_grad[i] = 0;
            tot_grad[i] = 0;
        end
        score  = 0;
        grid_x = 16;
        grid_y = 16;
        fails  = 0;
    endfunction

    function int add_sat(int a, longint b, ref bit sat);
        longint s;
        s = longint'(a) + b;
        if (s > 64'sd2147483647)
        begin
            sat = 1;
            return 32'h7fffffff;
        end
        if (s < -64'sd2147483648)
        begin
            sat = 1;
            return 32'h80000000;
        end
        return int'(s);
    endfunction

    function void note_request(in_t r);
        out_t   res;
        bit     sat;
        longint top;
        longint base;
        longint g [3];
        longint lam;
        longint s;
        int     m;
        sat = 0;
        res = '0;
        g[0] = longint'(r.grad_x);
        g[1] = longint'(r.grad_y);
        g[2] = longint'(r.grad_z);
        lam  = longint'(r.lambda);
        case (r.cmd)
            OP_LOAD:
                weights[r.tile_offset * ROW_WEIGHTS + r.weight_index] = r.value[15:0];
            OP_SC_CUR, OP_SC_TOT:
            begin
                top = 3 * ((longint'(r.pos_z + 3) * grid_y + r.pos_y + 3) * grid_x
                    + r.pos_x + 3) + 2;
                if (r.pos_x + 3 >= grid_x || r.pos_y + 3 >= grid_y || top >= MAX_COEFF)
                    res.status = ST_RANGE;
                else
                begin
                    m = 0;
                    for (int k = 0; k < SPAN; k++)
                        for (int j = 0; j < SPAN; j++)
                            for (int i = 0; i < SPAN; i++)
                            begin
                                base = 3 * ((longint'(r.pos_z + k) * grid_y + r.pos_y + j)
                                    * grid_x + r.pos_x + i);
                                for (int c = 0; c < 3; c++)
                                    if (r.cmd == OP_SC_CUR)
                                        cur_grad[base + c] = add_sat(cur_grad[base + c],
                                            g[c] * weights[r.tile_offset * ROW_WEIGHTS + m],
                                            sat);
                                    else
                                        tot_grad[base + c] = add_sat(tot_grad[base + c],
                                            g[c] * weights[r.tile_offset * ROW_WEIGHTS + m],
                                            sat);
                                m++;
                            end
                end
            end
            OP_FOLD:
            begin
                s = score + ((lam * longint'(r.value) + 2048) >>> 12);
                if (s > 64'sh7fffffffffff)
                begin
                    s = 64'sh7fffffffffff;
                    sat = 1;
                end
                if (s < -64'sh800000000000)
                begin
                    s = -64'sh800000000000;
                    sat = 1;
                end
                score = s;
                foreach (cur_grad[i])
                begin
                    tot_grad[i] = add_sat(tot_grad[i],
                        (lam * longint'(cur_grad[i]) + 2048) >>> 12, sat);
                    cur_grad[i] = 0;
                end
            end
            OP_CLEAR:
            begin
                foreach (cur_grad[i])
                begin
                    cur_grad[i] = 0;
                    tot_grad[i] = 0;
                end
                score = 0;
            end
            OP_READ:
                res.read_value = tot_grad[r.coeff_index];
            default: ;
        endcase
        if (sat && res.status == ST_OK)
            res.status = ST_SAT;
        res.score_sum = score[47:0];
        pending_q.push_back(res);
    endfunction

    function void check_result(out_t got);
        out_t want;
        if (pending_q.size() == 0)
        begin
            $error("unexpected result %h", got);
            fails++;
            return;
        end
        want = pending_q.pop_front();
        if (got.status !== want.status)
        begin
            $error("status: expected %0d actual %0d", want.status, got.status);
            fails++;
        end
        if (got.score_sum !== want.score_sum)
        begin
            $error("score_sum: expected %0d actual %0d", want.score_sum, got.score_sum);
            fails++;
        end
        if (got.read_value !== want.read_value)
        begin
            $error("read_value: expected %0d actual %0d", want.read_value, got.read_value);
            fails++;
        end
    endfunction
endclass

module tb_bspline_gradient_scatter_unit;
    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    logic cfg_we;
    logic cfg_index;
    logic [6:0] cfg_data;

    grad_scoreboard sb;
    bit   idle_on;
    bit   hold_req;
    bit   row_full [TILE_VOXELS];
    bit   wt_written [TILE_VOXELS * ROW_WEIGHTS];
    int   full_rows [$];
    int   n_sent;
    int   n_folds;
    int   n_clears;

    bspline_gradient_scatter_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_request(in_t r);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1;
        in_data  = r;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(r);
        if (r.cmd == OP_LOAD && !wt_written[r.tile_offset * ROW_WEIGHTS + r.weight_index])
        begin
            wt_written[r.tile_offset * ROW_WEIGHTS + r.weight_index] = 1;
            row_full[r.tile_offset] = 1;
            for (int i = 0; i < ROW_WEIGHTS; i++)
                if (!wt_written[r.tile_offset * ROW_WEIGHTS + i])
                    row_full[r.tile_offset] = 0;
            if (row_full[r.tile_offset])
                full_rows.push_back(int'(r.tile_offset));
        end
        n_sent++;
        @(negedge clk);
    endtask

    task automatic write_grid(int gx, int gy);
        in_valid = 0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_we    = 1;
        cfg_index = CFG_GRID_X;
        cfg_data  = gx[6:0];
        @(negedge clk);
        cfg_index = CFG_GRID_Y;
        cfg_data  = gy[6:0];
        @(negedge clk);
        cfg_we = 0;
        sb.grid_x = gx;
        sb.grid_y = gy;
    endtask

    function automatic in_t noise_request();
        in_t r;
        r = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        return r;
    endfunction

    function automatic logic [15:0] rand_grad();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_t scatter_request(bit to_total);
        in_t r;
        int  zmax;
        r = noise_request();
        r.cmd = to_total ? OP_SC_TOT : OP_SC_CUR;
        r.tile_offset = 9'(full_rows[$urandom_range(0, full_rows.size() - 1)]);
        r.grad_x = rand_grad();
        r.grad_y = rand_grad();
        r.grad_z = rand_grad();
        zmax = (sb.grid_x >= 4 && sb.grid_y >= 4) ?
            MAX_COEFF / (3 * sb.grid_x * sb.grid_y) - 4 : -1;
        if (zmax >= 0 && $urandom_range(0, 9) != 0)
        begin
            r.pos_x = 6'($urandom_range(0, sb.grid_x - 4));
            r.pos_y = 6'($urandom_range(0, sb.grid_y - 4));
            r.pos_z = 6'($urandom_range(0, zmax));
        end
        return r;
    endfunction

    task automatic load_row(int row);
        in_t r;
        for (int i = 0; i < ROW_WEIGHTS; i++)
        begin
            r = noise_request();
            r.cmd = OP_LOAD;
            r.tile_offset = 9'(row);
            r.weight_index = 6'(i);
            if (i == 0)
                r.value[15:0] = 16'hffff;
            else if (i == 1)
                r.value[15:0] = 16'h0000;
            send_request(r);
        end
    endtask

    task automatic random_phase(int count);
        in_t r;
        int  pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            r = noise_request();
            if (pick < 25)
            begin
                r.cmd = OP_LOAD;
                if ($urandom_range(0, 1))
                    r.tile_offset = 9'(full_rows[$urandom_range(0, full_rows.size() - 1)]);
            end
            else if (pick < 55)
                r = scatter_request(0);
            else if (pick < 70)
                r = scatter_request(1);
            else if (pick < 90)
                r.cmd = OP_READ;
            else if (pick < 93)
                r.cmd = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
            else if (pick < 95 && n_folds < 9)
            begin
                r.cmd = OP_FOLD;
                n_folds++;
            end
            else if (pick < 96 && n_clears < 3)
            begin
                r.cmd = OP_CLEAR;
                n_clears++;
            end
            else
                r.cmd = OP_READ;
            send_request(r);
        end
    endtask

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);

    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 0;
                repeat (300) @(negedge clk);
                hold_req = 0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready = 0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            out_ready = 1;
        end
    end

    initial
    begin
        in_t r;
        int  guard;
        sb        = new();
        rst_n     = 0;
        in_valid  = 0;
        in_data   = '0;
        cfg_we    = 0;
        cfg_index = CFG_GRID_X;
        cfg_data  = '0;
        idle_on   = 1;
        hold_req  = 0;
        n_sent    = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;

        load_row(0);
        load_row(TILE_VOXELS - 1);

        r = scatter_request(0);
        r.tile_offset = '0;
        r.grad_x = 16'h8000;
        r.grad_y = 16'h7fff;
        r.grad_z = 16'h8000;
        repeat (2) send_request(r);
        r.pos_x = 6'd63;
        send_request(r);
        r = scatter_request(1);
        r.tile_offset = 9'(TILE_VOXELS - 1);
        send_request(r);
        r = noise_request();
        r.cmd = OP_READ;
        r.coeff_index = '0;
        send_request(r);
        r.coeff_index = '1;
        send_request(r);
        r.cmd = OP_FOLD;
        r.lambda = 16'hffff;
        r.value = 32'sh7fffffff;
        send_request(r);
        r.lambda = 16'h0000;
        r.value = 32'sh80000000;
        send_request(r);
        r.cmd = OP_RSVD6;
        send_request(r);
        r.cmd = OP_RSVD7;
        send_request(r);
        r.cmd = OP_READ;
        r.coeff_index = 14'd1;
        send_request(r);
        r.cmd = OP_CLEAR;
        send_request(r);

        hold_req = 1;
        random_phase(60);
        write_grid(4, 4);
        random_phase(50);
        write_grid(64, 64);
        random_phase(30);
        write_grid(64, 4);
        random_phase(60);
        write_grid(4, 64);
        random_phase(60);
        write_grid(0, 127);
        random_phase(30);
        write_grid(16, 16);
        random_phase(60);
        idle_on = 0;
        random_phase(40);
        in_valid = 0;

        guard = 0;
        while (sb.pending_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
        if (sb.pending_q.size() != 0)
        begin
            $error("%0d results never arrived", sb.pending_q.size());
            sb.fails++;
        end
        $display("Sent %0d requests over six grid settings, including %0d folds", n_sent,
            n_folds + 2);
        $display("and %0d clears, with a long output stall and random idling.", n_clears + 1);
        if (sb.fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+design
design/bgs_pkg.sv
design/bgs_datapath.sv
design/bgs_ctrl.sv
design/bspline_gradient_scatter_unit.sv
bench/tb_bspline_gradient_scatter_unit.sv
